// ----- rtl/dcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// dcpe_pkg
// Shared types, constants and helper functions of the deconvolved CR-RC
// pulse evaluator.
// ----------------------------------------------------------------------------
package dcpe_pkg;

	// Field widths.
	localparam int TIME_W  = 16;
	localparam int TAP_W   = 18;
	localparam int OUT_W   = 32;
	localparam int BASE_W  = 24;
	localparam int AMP_W   = 24;
	localparam int TAU_W   = 16;
	localparam int SCALE_W = 16;
	localparam int SPOS_W  = 18;
	localparam int QUO_W   = 34;
	localparam int PEAK_W  = 40;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// Tap spacing of 25 ns in 1/64 ns units and the Q2.14 deconvolution weights.
	localparam int TAP_DELAY = 1600;
	localparam int W_LATE    = 19875;
	localparam int W_MID     = 24109;
	localparam int W_EARLY   = 7312;

	// Q.30 constants of the exponential.
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [30:0] EXP_M1_Q30 = 31'd395007542;
	localparam int          EXP_LIMIT  = 24;

	// Pipeline shape.
	localparam int DIV_STAGES   = 17;
	localparam int DIV_BITS     = 2;
	localparam int HORNER_TERMS = 9;
	localparam int LANE_STAGES  = 44;
	localparam int PIPE_STAGES  = LANE_STAGES + 3;

	// Register map indexes.
	typedef enum logic [2:0] {
		REG_BASELINE    = 3'd0,
		REG_TIME_OFFSET = 3'd1,
		REG_AMPLITUDE   = 3'd2,
		REG_DECAY_TIME  = 3'd3,
		REG_TIME_SCALE  = 3'd4
	} reg_idx_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic signed [BASE_W-1:0]  baseline;
		logic signed [TIME_W-1:0]  time_offset;
		logic signed [AMP_W-1:0]   amplitude;
		logic        [TAU_W-1:0]   decay_time;
		logic        [SCALE_W-1:0] time_scale;
	} cfg_t;

	// Partial state of the restoring divider.
	typedef struct packed {
		logic [TAU_W-1:0] rem;
		logic [QUO_W-1:0] num;
	} div_st_t;

	// One restoring division step: shift a dividend bit in, a quotient bit out.
	function automatic div_st_t div_step(input div_st_t d, input logic [TAU_W-1:0] tau);
		logic [TAU_W:0] t;
		div_st_t r;
		t = {d.rem, d.num[QUO_W-1]};
		r.num = {d.num[QUO_W-2:0], 1'b0};
		if (t >= {1'b0, tau}) begin
			r.rem = TAU_W'(t - {1'b0, tau});
			r.num[0] = 1'b1;
		end else begin
			r.rem = t[TAU_W-1:0];
		end
		return r;
	endfunction

	// Integer powers of exp(-1) in Q.30, each product rounded half up.
	typedef logic [30:0] exp_tbl_t [32];

	function automatic exp_tbl_t exp_tbl_init();
		exp_tbl_t tbl;
		logic [61:0] acc;
		acc = 62'(ONE_Q30);
		for (int k = 0; k < 32; k++) begin
			tbl[k] = (k <= EXP_LIMIT) ? acc[30:0] : '0;
			acc = ((acc * 62'(EXP_M1_Q30)) + 62'(ONE_Q30 >> 1)) >> 30;
		end
		return tbl;
	endfunction

	localparam exp_tbl_t EXP_TBL = exp_tbl_init();

endpackage

// ----- rtl/dcpe_ifs.sv -----
// ----------------------------------------------------------------------------
// dcpe_ifs
// Valid/ready channels of the pulse evaluator: time points in, model values out.
// ----------------------------------------------------------------------------

// Channel that carries one time point per item.
interface dcpe_sample_if;
	import dcpe_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TIME_W-1:0] time_point;
	modport source(output valid, output time_point, input ready);
	modport sink(input valid, input time_point, output ready);
endinterface

// Channel that carries one model value per item.
interface dcpe_result_if;
	import dcpe_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] model_value;
	modport source(output valid, output model_value, input ready);
	modport sink(input valid, input model_value, output ready);
endinterface

// ----- rtl/dcpe_lane.sv -----
// ----------------------------------------------------------------------------
// dcpe_lane
// Pipelined CR-RC peak evaluation for one tap: time scaling, t/tau divider,
// exp(-t/tau) and the amplitude product.
// ----------------------------------------------------------------------------
module dcpe_lane (
	input  logic                             clk,
	input  logic                             en,
	input  dcpe_pkg::cfg_t                   cfg,
	input  logic signed [dcpe_pkg::TAP_W-1:0] tap,
	output logic signed [dcpe_pkg::PEAK_W-1:0] peak
);
	import dcpe_pkg::*;

	logic signed [34:0]   prod_s1;
	logic [SPOS_W-1:0]    s_s2;
	logic signed [34:0]   rnd;
	logic signed [20:0]   x;
	logic signed [21:0]   s_full;
	logic [TAU_W-1:0]     tau_eff;

	div_st_t              div_s [1:DIV_STAGES];
	logic [SPOS_W-1:0]    dsv_s [1:DIV_STAGES];

	logic [QUO_W-1:0]     q;
	logic                 big;
	logic [30:0]          hacc_s [0:2*HORNER_TERMS];
	logic [SPOS_W-1:0]    hs_s   [0:2*HORNER_TERMS];
	logic [15:0]          hf_s   [0:2*HORNER_TERMS-2];
	logic [29:0]          hv_s   [0:HORNER_TERMS-1];
	logic [30:0]          hser_s [1:HORNER_TERMS];

	logic [61:0]          mprod_s39;
	logic [SPOS_W-1:0]    s_s39;
	logic [61:0]          mrnd;
	logic [32:0]          ernd;
	logic [16:0]          e_s40;
	logic [SPOS_W-1:0]    s_s40;
	logic [34:0]          p_s41;
	logic signed [42:0]   lo_s42;
	logic signed [41:0]   hi_s42;
	logic signed [60:0]   tot;
	logic signed [38:0]   term_s43;

	// A zero time constant counts as one.
	assign tau_eff = (cfg.decay_time == '0) ? TAU_W'(1) : cfg.decay_time;

	// Scale the tap time.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed({1'b0, cfg.time_scale}) * tap;
		end
	end

	// Round to 1/64 ns, add the offset, clamp negative times to zero.
	always_comb begin
		rnd = prod_s1 + 35'sd8192;
		x = rnd[34:14];
		s_full = $signed({x[20], x}) +
			$signed({{6{cfg.time_offset[TIME_W-1]}}, cfg.time_offset});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= s_full[21] ? '0 : s_full[SPOS_W-1:0];
		end
	end

	// Divider for t/tau in Q.16, two quotient bits per stage.
	for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
		div_st_t           d_in;
		div_st_t           d_out;
		logic [SPOS_W-1:0] s_in;

		if (g == 1) begin : g_first
			assign d_in = div_st_t'({16'd0, s_s2, 16'd0});
			assign s_in = s_s2;
		end else begin : g_next
			assign d_in = div_s[g-1];
			assign s_in = dsv_s[g-1];
		end

		always_comb begin
			d_out = d_in;
			for (int b = 0; b < DIV_BITS; b++) begin
				d_out = div_step(d_out, tau_eff);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g] <= d_out;
				dsv_s[g] <= s_in;
			end
		end
	end

	// Integer part of t/tau picks a power of exp(-1); beyond the cutoff it is zero.
	assign q   = div_s[DIV_STAGES].num;
	assign big = q > QUO_W'(EXP_LIMIT << 16);

	always_ff @(posedge clk) begin
		if (en) begin
			hacc_s[0] <= big ? '0 : EXP_TBL[q[20:16]];
			hf_s[0]   <= q[15:0];
			hs_s[0]   <= dsv_s[DIV_STAGES];
		end
	end

	// Carry the operands along the series stages.
	for (genvar j = 0; j < 2*HORNER_TERMS; j++) begin : g_carry
		always_ff @(posedge clk) begin
			if (en) begin
				hacc_s[j+1] <= hacc_s[j];
				hs_s[j+1]   <= hs_s[j];
			end
		end
		if (j < 2*HORNER_TERMS-2) begin : g_frac
			always_ff @(posedge clk) begin
				if (en) begin
					hf_s[j+1] <= hf_s[j];
				end
			end
		end
	end

	// Horner series of exp(-f): multiply stage, then divide-by-term stage.
	for (genvar k = 0; k < HORNER_TERMS; k++) begin : g_horner
		localparam int D = HORNER_TERMS - k;
		logic [30:0] ser_in;
		logic [46:0] fprod;
		logic [29:0] quo;

		if (k == 0) begin : g_one
			assign ser_in = ONE_Q30;
		end else begin : g_prev
			assign ser_in = hser_s[k];
		end

		assign fprod = 47'(hf_s[2*k]) * 47'(ser_in);

		always_ff @(posedge clk) begin
			if (en) begin
				hv_s[k] <= fprod[45:16];
			end
		end

		if ((D & (D - 1)) == 0) begin : g_shift
			assign quo = hv_s[k] >> $clog2(D);
		end else begin : g_recip
			// Reciprocal is exact for 30-bit operands with a 34-bit shift.
			localparam logic [33:0] RECIP = 34'(((64'd1 << 34) + 64'(D) - 64'd1) / 64'(D));
			logic [63:0] rprod;
			assign rprod = 64'(hv_s[k]) * 64'(RECIP);
			assign quo = rprod[63:34];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hser_s[k+1] <= ONE_Q30 - {1'b0, quo};
			end
		end
	end

	// Integer power times fractional series.
	always_ff @(posedge clk) begin
		if (en) begin
			mprod_s39 <= 62'(hacc_s[2*HORNER_TERMS]) * 62'(hser_s[HORNER_TERMS]);
			s_s39     <= hs_s[2*HORNER_TERMS];
		end
	end

	// Round to Q.30, then to Q.16.
	always_comb begin
		mrnd = mprod_s39 + 62'(ONE_Q30 >> 1);
		ernd = {1'b0, mrnd[61:30]} + 33'd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s40 <= ernd[30:14];
			s_s40 <= s_s39;
		end
	end

	// t * exp(-t/tau).
	always_ff @(posedge clk) begin
		if (en) begin
			p_s41 <= 35'(s_s40) * 35'(e_s40);
		end
	end

	// Amplitude product, split into two partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s42 <= cfg.amplitude * $signed({1'b0, p_s41[17:0]});
			hi_s42 <= cfg.amplitude * $signed({1'b0, p_s41[34:18]});
		end
	end

	// Join the partial products and round half up to Q.8.
	assign tot = $signed({hi_s42[41], hi_s42, 18'd0}) +
		$signed({{18{lo_s42[42]}}, lo_s42}) + 61'sd2097152;

	always_ff @(posedge clk) begin
		if (en) begin
			term_s43 <= tot[60:22];
		end
	end

	// Add the pedestal.
	always_ff @(posedge clk) begin
		if (en) begin
			peak <= $signed({{16{cfg.baseline[BASE_W-1]}}, cfg.baseline}) +
				$signed({term_s43[38], term_s43});
		end
	end

endmodule

// ----- rtl/deconvolved_crrc_pulse_evaluator.sv -----
// ----------------------------------------------------------------------------
// deconvolved_crrc_pulse_evaluator
// Evaluates the deconvolved CR-RC pulse model at one time point per item.
//
//   channel  | kind        | carries
//   ---------+-------------+------------------------------------------
//   sample   | valid/ready | time_point, 16 bit signed, 1/64 ns
//   result   | valid/ready | model_value, 32 bit signed Q24.8
//   p*       | APB         | five configuration registers at 4*index
//
// One item enters per cycle while the output does not stall; each tap lane
// holds a 17-stage t/tau divider and an 18-stage exponential series.
// Reset clears all valid bits and loads the configuration defaults.
// A result that is not taken freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module deconvolved_crrc_pulse_evaluator (
	input  logic                         clk,
	input  logic                         arst_n,
	dcpe_sample_if.sink                  sample,
	dcpe_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dcpe_pkg::ADDR_W-1:0]  paddr,
	input  logic [dcpe_pkg::DATA_W-1:0]  pwdata,
	output logic [dcpe_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import dcpe_pkg::*;

	cfg_t                     cfg_q;
	logic                     en;
	logic [PIPE_STAGES:1]     vld_s;
	logic signed [TAP_W-1:0]  tap [3];
	logic signed [PEAK_W-1:0] peak [3];
	logic signed [55:0]       wl_s45;
	logic signed [55:0]       wm_s45;
	logic signed [55:0]       we_s45;
	logic signed [57:0]       sum_s46;
	logic signed [57:0]       rsum;
	logic signed [43:0]       rnd;
	logic signed [OUT_W-1:0]  res_s47;

	// Configuration register writes.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.baseline    <= '0;
			cfg_q.time_offset <= '0;
			cfg_q.amplitude   <= 24'sd256;
			cfg_q.decay_time  <= 16'd3200;
			cfg_q.time_scale  <= 16'd16384;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_BASELINE:    cfg_q.baseline    <= pwdata[BASE_W-1:0];
				REG_TIME_OFFSET: cfg_q.time_offset <= pwdata[TIME_W-1:0];
				REG_AMPLITUDE:   cfg_q.amplitude   <= pwdata[AMP_W-1:0];
				REG_DECAY_TIME:  cfg_q.decay_time  <= pwdata[TAU_W-1:0];
				REG_TIME_SCALE:  cfg_q.time_scale  <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback, signed fields sign-extended.
	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_BASELINE:    prdata = DATA_W'(cfg_q.baseline);
			REG_TIME_OFFSET: prdata = DATA_W'(cfg_q.time_offset);
			REG_AMPLITUDE:   prdata = DATA_W'(cfg_q.amplitude);
			REG_DECAY_TIME:  prdata = DATA_W'(cfg_q.decay_time);
			REG_TIME_SCALE:  prdata = DATA_W'(cfg_q.time_scale);
			default:         prdata = '0;
		endcase
	end

	// The pipeline advances unless a finished item waits at the output.
	assign en = !vld_s[PIPE_STAGES] || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_STAGES-1:1], sample.valid};
		end
	end

	// Three taps at +25 ns, 0 ns and -25 ns.
	assign tap[0] = $signed({{2{sample.time_point[TIME_W-1]}}, sample.time_point}) +
		18'sd1600;
	assign tap[1] = $signed({{2{sample.time_point[TIME_W-1]}}, sample.time_point});
	assign tap[2] = $signed({{2{sample.time_point[TIME_W-1]}}, sample.time_point}) -
		18'sd1600;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		dcpe_lane u_lane (
			.clk  (clk),
			.en   (en),
			.cfg  (cfg_q),
			.tap  (tap[i]),
			.peak (peak[i])
		);
	end

	// Deconvolution weights.
	always_ff @(posedge clk) begin
		if (en) begin
			wl_s45 <= peak[0] * $signed(16'(W_LATE));
			wm_s45 <= peak[1] * $signed(16'(W_MID));
			we_s45 <= peak[2] * $signed(16'(W_EARLY));
		end
	end

	// Weighted sum.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s46 <= $signed({{2{wl_s45[55]}}, wl_s45}) -
				$signed({{2{wm_s45[55]}}, wm_s45}) +
				$signed({{2{we_s45[55]}}, we_s45});
		end
	end

	// Round half up out of Q2.14 and saturate to 32 bits.
	always_comb begin
		rsum = sum_s46 + 58'sd8192;
		rnd = rsum[57:14];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (rnd > 44'sd2147483647) begin
				res_s47 <= 32'sh7FFF_FFFF;
			end else if (rnd < -44'sd2147483648) begin
				res_s47 <= 32'sh8000_0000;
			end else begin
				res_s47 <= rnd[OUT_W-1:0];
			end
		end
	end

	assign result.valid       = vld_s[PIPE_STAGES];
	assign result.model_value = res_s47;

	// A waiting result blocks new items.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !sample.ready)
		else $error("item accepted while a result waits");

	// A stall freezes every valid bit in the pipeline.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved during a stall");

	// An accepted item occupies the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> vld_s[1])
		else $error("accepted item did not enter the pipeline");

endmodule
